FILE: hw/rtl/beu_pkg.sv
// ----------------------------------------------------------------------------
// beu_pkg
// Shared types, constants and arithmetic helpers for the Euler step unit.
// ----------------------------------------------------------------------------
package beu_pkg;

    // Fixed-point widths (Q16.16 values, Q0.16 time step)
    localparam int unsigned Q_W    = 32;
    localparam int unsigned DT_W   = 16;
    localparam int unsigned EXT_W  = 31;
    localparam int unsigned PROD_W = Q_W + DT_W;
    localparam int unsigned FRAC_W = 16;

    // Configuration port
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    // Largest usable time step (0.5 in Q0.16)
    localparam logic [DT_W-1:0] DT_MAX = 16'd32768;

    // Bounded-mode edge behavior: margin 20.0, push 10.0 (Q16.16)
    localparam logic signed [Q_W-1:0] EDGE_MARGIN = 32'sd1310720;
    localparam logic signed [Q_W-1:0] EDGE_PUSH   = 32'sd655360;

    // Rounding offset for the Q16.32 -> Q16.16 step (one half LSB)
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 48'sd32768;

    // Pipeline depth of one axis datapath
    localparam int unsigned PIPE_DEPTH = 6;

    // Register reset values
    localparam logic [DT_W-1:0]  RST_TIME_STEP = 16'd3277;
    localparam logic [EXT_W-1:0] RST_WINDOW    = 31'd52428800;
    localparam logic [EXT_W-1:0] RST_SPEED_LIM = 31'd6553600;

    // Register map (word index = paddr[4:2])
    typedef enum logic [2:0] {
        REG_TIME_STEP     = 3'd0,
        REG_WINDOW_WIDTH  = 3'd1,
        REG_WINDOW_HEIGHT = 3'd2,
        REG_WRAP_MODE     = 3'd3,
        REG_WRAP_SPEED    = 3'd4,
        REG_BOUNDED_SPEED = 3'd5
    } t_reg_idx;

    // Full configuration as held by the register block
    typedef struct packed {
        logic [DT_W-1:0]  time_step;
        logic [EXT_W-1:0] window_width;
        logic [EXT_W-1:0] window_height;
        logic             wrap_mode;
        logic [EXT_W-1:0] wrap_speed_limit;
        logic [EXT_W-1:0] bounded_speed_limit;
    } t_cfg;

    // Configuration seen by one axis datapath
    typedef struct packed {
        logic [DT_W-1:0]  dt;
        logic [EXT_W-1:0] extent;
        logic             wrap_mode;
        logic [EXT_W-1:0] wrap_lim;
        logic [EXT_W-1:0] bnd_lim;
    } t_axis_cfg;

    // Saturate a 33-bit signed sum to the Q16.16 range
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [Q_W:0] v);
        logic signed [Q_W-1:0] res;
        if (v[Q_W] != v[Q_W-1]) begin
            res = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // Round a Q16.32 product to Q16.16, ties toward plus infinity
    function automatic logic signed [Q_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + ROUND_HALF;
        return s[PROD_W-1:FRAC_W];
    endfunction

endpackage

FILE: hw/rtl/beu_cfg_regs.sv
// ----------------------------------------------------------------------------
// beu_cfg_regs
// APB register block for the step, window, wrap mode and speed-limit settings.
// ----------------------------------------------------------------------------
module beu_cfg_regs
    import beu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Decode write transfers; unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_TIME_STEP:     n_cfg.time_step           = pwdata[DT_W-1:0];
                REG_WINDOW_WIDTH:  n_cfg.window_width        = pwdata[EXT_W-1:0];
                REG_WINDOW_HEIGHT: n_cfg.window_height       = pwdata[EXT_W-1:0];
                REG_WRAP_MODE:     n_cfg.wrap_mode           = pwdata[0];
                REG_WRAP_SPEED:    n_cfg.wrap_speed_limit    = pwdata[EXT_W-1:0];
                REG_BOUNDED_SPEED: n_cfg.bounded_speed_limit = pwdata[EXT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step           <= RST_TIME_STEP;
            r_cfg.window_width        <= RST_WINDOW;
            r_cfg.window_height       <= RST_WINDOW;
            r_cfg.wrap_mode           <= 1'b0;
            r_cfg.wrap_speed_limit    <= RST_SPEED_LIM;
            r_cfg.bounded_speed_limit <= RST_SPEED_LIM;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_TIME_STEP:     prdata = {{(APB_DW-DT_W){1'b0}}, r_cfg.time_step};
            REG_WINDOW_WIDTH:  prdata = {{(APB_DW-EXT_W){1'b0}}, r_cfg.window_width};
            REG_WINDOW_HEIGHT: prdata = {{(APB_DW-EXT_W){1'b0}}, r_cfg.window_height};
            REG_WRAP_MODE:     prdata = {{(APB_DW-1){1'b0}}, r_cfg.wrap_mode};
            REG_WRAP_SPEED:    prdata = {{(APB_DW-EXT_W){1'b0}}, r_cfg.wrap_speed_limit};
            REG_BOUNDED_SPEED: prdata = {{(APB_DW-EXT_W){1'b0}}, r_cfg.bounded_speed_limit};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/beu_axis_pipe.sv
// ----------------------------------------------------------------------------
// beu_axis_pipe
// Six-stage datapath for one axis: velocity and position update, then
// wrap or edge push, then speed clamp.
// ----------------------------------------------------------------------------
module beu_axis_pipe
    import beu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_axis_cfg             i_cfg,
    input  logic signed [Q_W-1:0] i_vel,
    input  logic signed [Q_W-1:0] i_pos,
    input  logic signed [Q_W-1:0] i_acc,
    output logic signed [Q_W-1:0] o_vel,
    output logic signed [Q_W-1:0] o_pos
);

    logic signed [DT_W:0]     w_dt;
    logic signed [Q_W:0]      w_ext;
    logic signed [Q_W:0]      w_hi_edge;

    logic signed [PROD_W-1:0] r1_prod;
    logic signed [Q_W-1:0]    r1_vel;
    logic signed [Q_W-1:0]    r1_pos;
    logic signed [Q_W-1:0]    w_acc_step;

    logic signed [Q_W-1:0]    r2_vel;
    logic signed [Q_W-1:0]    r2_pos;

    logic signed [PROD_W-1:0] r3_prod;
    logic signed [Q_W-1:0]    r3_vel;
    logic signed [Q_W-1:0]    r3_pos;
    logic signed [Q_W-1:0]    w_vel_step;

    logic signed [Q_W-1:0]    r4_vel;
    logic signed [Q_W-1:0]    r4_pos;

    logic signed [Q_W-1:0]    r5_vel;
    logic signed [Q_W-1:0]    r5_pos;
    logic [EXT_W-1:0]         r5_lim;
    logic signed [Q_W-1:0]    n5_vel;
    logic signed [Q_W-1:0]    n5_pos;
    logic signed [Q_W-1:0]    w_push;

    logic signed [Q_W-1:0]    r6_vel;
    logic signed [Q_W-1:0]    r6_pos;
    logic signed [Q_W-1:0]    n6_vel;
    logic signed [Q_W:0]      w_lim;

    assign w_dt      = $signed({1'b0, i_cfg.dt});
    assign w_ext     = $signed({2'b00, i_cfg.extent});
    assign w_hi_edge = w_ext - Q_W'(EDGE_MARGIN);

    // Round the scaled products back to Q16.16
    assign w_acc_step = round_q(r1_prod);
    assign w_vel_step = round_q(r3_prod);

    // Stage 5: wrap the position or push the velocity off the edges
    always_comb begin
        n5_pos = r4_pos;
        n5_vel = r4_vel;
        w_push = r4_vel;
        if (i_cfg.wrap_mode) begin
            if (r4_pos < 0) begin
                n5_pos = w_ext[Q_W-1:0];
            end
            if ($signed({n5_pos[Q_W-1], n5_pos}) > w_ext) begin
                n5_pos = '0;
            end
        end else begin
            if (r4_pos < EDGE_MARGIN) begin
                w_push = sat32($signed({r4_vel[Q_W-1], r4_vel}) + EDGE_PUSH);
            end
            n5_vel = w_push;
            if ($signed({r4_pos[Q_W-1], r4_pos}) > w_hi_edge) begin
                n5_vel = sat32($signed({w_push[Q_W-1], w_push}) - EDGE_PUSH);
            end
        end
    end

    // Stage 6: clamp each velocity axis to the selected limit
    assign w_lim = $signed({2'b00, r5_lim});
    always_comb begin
        n6_vel = r5_vel;
        if ($signed({r5_vel[Q_W-1], r5_vel}) > w_lim) begin
            n6_vel = w_lim[Q_W-1:0];
        end else if ($signed({r5_vel[Q_W-1], r5_vel}) < -w_lim) begin
            n6_vel = -w_lim[Q_W-1:0];
        end
    end

    // Advance all stages together when the pipeline is not held
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: acceleration times step
            r1_prod <= PROD_W'(i_acc * w_dt);
            r1_vel  <= i_vel;
            r1_pos  <= i_pos;
            // stage 2: round and add to velocity
            r2_vel  <= sat32($signed({r1_vel[Q_W-1], r1_vel})
                             + $signed({w_acc_step[Q_W-1], w_acc_step}));
            r2_pos  <= r1_pos;
            // stage 3: new velocity times step
            r3_prod <= PROD_W'(r2_vel * w_dt);
            r3_vel  <= r2_vel;
            r3_pos  <= r2_pos;
            // stage 4: round and add to position
            r4_pos  <= sat32($signed({r3_pos[Q_W-1], r3_pos})
                             + $signed({w_vel_step[Q_W-1], w_vel_step}));
            r4_vel  <= r3_vel;
            // stage 5
            r5_vel  <= n5_vel;
            r5_pos  <= n5_pos;
            r5_lim  <= i_cfg.wrap_mode ? i_cfg.wrap_lim : i_cfg.bnd_lim;
            // stage 6
            r6_vel  <= n6_vel;
            r6_pos  <= r5_pos;
        end
    end

    assign o_vel = r6_vel;
    assign o_pos = r6_pos;

endmodule

FILE: hw/rtl/boid_euler_step_unit.sv
// ----------------------------------------------------------------------------
// boid_euler_step_unit
// Semi-implicit Euler step for one agent in 2D, Q16.16, with toroidal wrap or
// bounded edge push and a per-axis speed clamp.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  in       | i_valid / o_stall  | i_vel_x/y, i_pos_x/y, i_accel_x/y
//  out      | o_valid / i_stall  | o_new_vel_x/y, o_new_pos_x/y
//  config   | APB psel..pready   | paddr, pwdata, prdata
//
//  One agent enters per cycle while the output is not stalled; each result
//  passes through the six register stages of the axis datapath (two multiply,
//  two round/add, edge handling, clamp). A stall on the output while a result
//  waits there holds every stage; an input skid register takes the item
//  presented in that cycle, so o_stall is a registered signal.
//  Reset (synchronous, active low) empties the pipeline and the skid
//  register and restores the register defaults.
// ----------------------------------------------------------------------------
module boid_euler_step_unit
    import beu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [Q_W-1:0] i_vel_x,
    input  logic signed [Q_W-1:0] i_vel_y,
    input  logic signed [Q_W-1:0] i_pos_x,
    input  logic signed [Q_W-1:0] i_pos_y,
    input  logic signed [Q_W-1:0] i_accel_x,
    input  logic signed [Q_W-1:0] i_accel_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [Q_W-1:0] o_new_vel_x,
    output logic signed [Q_W-1:0] o_new_vel_y,
    output logic signed [Q_W-1:0] o_new_pos_x,
    output logic signed [Q_W-1:0] o_new_pos_y,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    t_cfg                  w_cfg;
    t_axis_cfg             w_cfg_x;
    t_axis_cfg             w_cfg_y;
    logic [DT_W-1:0]       w_dt;

    logic                  w_en;
    logic                  w_in_xfer;
    logic [PIPE_DEPTH-1:0] r_vld;

    logic                  r_skid_vld;
    logic signed [Q_W-1:0] r_skid_vel_x;
    logic signed [Q_W-1:0] r_skid_vel_y;
    logic signed [Q_W-1:0] r_skid_pos_x;
    logic signed [Q_W-1:0] r_skid_pos_y;
    logic signed [Q_W-1:0] r_skid_acc_x;
    logic signed [Q_W-1:0] r_skid_acc_y;

    logic                  w_src_vld;
    logic signed [Q_W-1:0] w_src_vel_x;
    logic signed [Q_W-1:0] w_src_vel_y;
    logic signed [Q_W-1:0] w_src_pos_x;
    logic signed [Q_W-1:0] w_src_pos_y;
    logic signed [Q_W-1:0] w_src_acc_x;
    logic signed [Q_W-1:0] w_src_acc_y;

    beu_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Limit the time step to 0.5 and split the settings per axis
    assign w_dt = (w_cfg.time_step > DT_MAX) ? DT_MAX : w_cfg.time_step;

    assign w_cfg_x = '{dt: w_dt, extent: w_cfg.window_width,
                       wrap_mode: w_cfg.wrap_mode, wrap_lim: w_cfg.wrap_speed_limit,
                       bnd_lim: w_cfg.bounded_speed_limit};
    assign w_cfg_y = '{dt: w_dt, extent: w_cfg.window_height,
                       wrap_mode: w_cfg.wrap_mode, wrap_lim: w_cfg.wrap_speed_limit,
                       bnd_lim: w_cfg.bounded_speed_limit};

    // Hold the pipeline only when a finished result is not taken
    assign w_en      = !(r_vld[PIPE_DEPTH-1] && i_stall);
    assign o_stall   = r_skid_vld;
    assign w_in_xfer = i_valid && !r_skid_vld;

    // Feed the pipeline from the skid register first
    assign w_src_vld   = r_skid_vld || i_valid;
    assign w_src_vel_x = r_skid_vld ? r_skid_vel_x : i_vel_x;
    assign w_src_vel_y = r_skid_vld ? r_skid_vel_y : i_vel_y;
    assign w_src_pos_x = r_skid_vld ? r_skid_pos_x : i_pos_x;
    assign w_src_pos_y = r_skid_vld ? r_skid_pos_y : i_pos_y;
    assign w_src_acc_x = r_skid_vld ? r_skid_acc_x : i_accel_x;
    assign w_src_acc_y = r_skid_vld ? r_skid_acc_y : i_accel_y;

    // Skid control and valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (w_en) begin
                r_vld      <= {r_vld[PIPE_DEPTH-2:0], w_src_vld};
                r_skid_vld <= 1'b0;
            end else if (w_in_xfer) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    // Capture the item that arrives while the pipeline is held
    always_ff @(posedge i_clk) begin
        if (!w_en && w_in_xfer) begin
            r_skid_vel_x <= i_vel_x;
            r_skid_vel_y <= i_vel_y;
            r_skid_pos_x <= i_pos_x;
            r_skid_pos_y <= i_pos_y;
            r_skid_acc_x <= i_accel_x;
            r_skid_acc_y <= i_accel_y;
        end
    end

    beu_axis_pipe u_axis_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (w_cfg_x),
        .i_vel (w_src_vel_x),
        .i_pos (w_src_pos_x),
        .i_acc (w_src_acc_x),
        .o_vel (o_new_vel_x),
        .o_pos (o_new_pos_x)
    );

    beu_axis_pipe u_axis_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_cfg (w_cfg_y),
        .i_vel (w_src_vel_y),
        .i_pos (w_src_pos_y),
        .i_acc (w_src_acc_y),
        .o_vel (o_new_vel_y),
        .o_pos (o_new_pos_y)
    );

    assign o_valid = r_vld[PIPE_DEPTH-1];

endmodule

FILE: hw/rtl/beu_checker.sv
// ----------------------------------------------------------------------------
// beu_checker
// Port-level checks for the Euler step unit, bound to the top level.
// ----------------------------------------------------------------------------
module beu_checker
    import beu_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic signed [Q_W-1:0] o_new_vel_x,
    input logic signed [Q_W-1:0] o_new_pos_x,
    input logic                  pready
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_new_vel_x) && $stable(o_new_pos_x))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall present after reset");

    // Input back-pressure only follows a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall && i_valid))
        else $error("input stall without a held result");

    // While the skid register is full, a result waits at the output
    a_skid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && pready)
        else $error("skid register full with empty output");

endmodule

bind boid_euler_step_unit beu_checker u_beu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_new_vel_x (o_new_vel_x),
    .o_new_pos_x (o_new_pos_x),
    .pready      (pready)
);

FILE: test/beu_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beu_step_checker
// Watches the agent, result and register channels of the Euler step unit.
// Keeps its own copy of the registers, predicts the updated velocity and
// position of every agent at its transfer, and compares the results in
// order, field by field.
// ----------------------------------------------------------------------------
module beu_step_checker
    import beu_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // agent channel
    input  logic                  i_agent_valid,
    input  logic                  i_agent_stall,
    input  logic signed [Q_W-1:0] i_vel_x,
    input  logic signed [Q_W-1:0] i_vel_y,
    input  logic signed [Q_W-1:0] i_pos_x,
    input  logic signed [Q_W-1:0] i_pos_y,
    input  logic signed [Q_W-1:0] i_accel_x,
    input  logic signed [Q_W-1:0] i_accel_y,
    // result channel
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic signed [Q_W-1:0] i_new_vel_x,
    input  logic signed [Q_W-1:0] i_new_vel_y,
    input  logic signed [Q_W-1:0] i_new_pos_x,
    input  logic signed [Q_W-1:0] i_new_pos_y,
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    input  logic                  pready,
    // status for the testbench top
    output int                    o_err_count,
    output int                    o_pending
);

    localparam longint Q_HI        = 64'sd2147483647;
    localparam longint Q_LO        = -64'sd2147483648;
    localparam int     MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [Q_W-1:0] vel;
        logic signed [Q_W-1:0] pos;
    } t_axis_state;

    typedef struct packed {
        logic signed [Q_W-1:0] new_vel_x;
        logic signed [Q_W-1:0] new_vel_y;
        logic signed [Q_W-1:0] new_pos_x;
        logic signed [Q_W-1:0] new_pos_y;
    } t_agent_update;

    // Register copy
    logic [DT_W-1:0]  cfg_step;
    logic [EXT_W-1:0] cfg_width;
    logic [EXT_W-1:0] cfg_height;
    logic             cfg_wrap;
    logic [EXT_W-1:0] cfg_wrap_lim;
    logic [EXT_W-1:0] cfg_bnd_lim;

    t_agent_update predicted_updates[$];
    int            err_total = 0;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    // Saturate to the Q16.16 range
    function automatic longint clip_q(input longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    // Scale by the Q0.16 step, round to nearest with halves going up
    function automatic longint times_step(input longint a, input longint dt);
        return (a * dt + 64'sd32768) >>> 16;
    endfunction

    function automatic longint limit_speed(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // One axis: advance velocity, then position, then wrap or edge push, then speed limit
    function automatic t_axis_state advance_axis(input longint vel, input longint pos,
                                                 input longint acc, input longint extent);
        longint      dt;
        longint      v;
        longint      p;
        t_axis_state r;
        dt = (cfg_step > DT_MAX) ? longint'(DT_MAX) : longint'(cfg_step);
        v  = clip_q(vel + times_step(acc, dt));
        p  = clip_q(pos + times_step(v, dt));
        if (cfg_wrap) begin
            if (p < 0) p = extent;
            if (p > extent) p = 0;
            v = limit_speed(v, longint'(cfg_wrap_lim));
        end else begin
            if (p < longint'(EDGE_MARGIN)) v = clip_q(v + longint'(EDGE_PUSH));
            if (p > extent - longint'(EDGE_MARGIN)) v = clip_q(v - longint'(EDGE_PUSH));
            v = limit_speed(v, longint'(cfg_bnd_lim));
        end
        r.vel = v[Q_W-1:0];
        r.pos = p[Q_W-1:0];
        return r;
    endfunction

    function automatic t_agent_update predict_step();
        t_axis_state   ax;
        t_axis_state   ay;
        t_agent_update u;
        ax = advance_axis(longint'(i_vel_x), longint'(i_pos_x), longint'(i_accel_x),
                          longint'(cfg_width));
        ay = advance_axis(longint'(i_vel_y), longint'(i_pos_y), longint'(i_accel_y),
                          longint'(cfg_height));
        u.new_vel_x = ax.vel;
        u.new_vel_y = ay.vel;
        u.new_pos_x = ax.pos;
        u.new_pos_y = ay.pos;
        return u;
    endfunction

    // Count a failure, report only the first few
    task automatic flag_error(input string msg);
        err_total++;
        if (err_total <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic signed [Q_W-1:0] want,
                                 input logic signed [Q_W-1:0] got);
        if (got !== want) begin
            flag_error($sformatf("%s mismatch: expected %0d (%h), got %0d (%h)",
                                 name, want, want, got, got));
        end
    endtask

    // Track register writes, predict on agent transfers, check result transfers
    always @(posedge i_clk) begin : watch
        t_agent_update want;
        if (!i_rst_n) begin
            cfg_step     <= RST_TIME_STEP;
            cfg_width    <= RST_WINDOW;
            cfg_height   <= RST_WINDOW;
            cfg_wrap     <= 1'b0;
            cfg_wrap_lim <= RST_SPEED_LIM;
            cfg_bnd_lim  <= RST_SPEED_LIM;
            predicted_updates.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_TIME_STEP:     cfg_step     <= pwdata[DT_W-1:0];
                    REG_WINDOW_WIDTH:  cfg_width    <= pwdata[EXT_W-1:0];
                    REG_WINDOW_HEIGHT: cfg_height   <= pwdata[EXT_W-1:0];
                    REG_WRAP_MODE:     cfg_wrap     <= pwdata[0];
                    REG_WRAP_SPEED:    cfg_wrap_lim <= pwdata[EXT_W-1:0];
                    REG_BOUNDED_SPEED: cfg_bnd_lim  <= pwdata[EXT_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (predicted_updates.size() == 0) begin
                    flag_error($sformatf("result transfer with none expected: %h %h %h %h",
                                         i_new_vel_x, i_new_vel_y, i_new_pos_x, i_new_pos_y));
                end else begin
                    want = predicted_updates.pop_front();
                    compare_field("new_vel_x", want.new_vel_x, i_new_vel_x);
                    compare_field("new_vel_y", want.new_vel_y, i_new_vel_y);
                    compare_field("new_pos_x", want.new_pos_x, i_new_pos_x);
                    compare_field("new_pos_y", want.new_pos_y, i_new_pos_y);
                end
            end
            if (i_agent_valid && !i_agent_stall) begin
                predicted_updates.push_back(predict_step());
            end
        end
        o_err_count <= err_total;
        o_pending   <= predicted_updates.size();
    end

endmodule

FILE: test/tb_boid_euler_step_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_boid_euler_step_unit
// Drives agents into the Euler step unit under several register settings:
// a directed set of edge, wrap, rounding and saturation cases, then random
// agents with idle cycles on the input and stalls on the output. The checker
// beside the unit predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_boid_euler_step_unit;
    import beu_pkg::*;

    localparam int Q_ONE           = 65536;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int RANDOM_PHASES   = 8;
    localparam int CALM_PHASE      = 3;
    localparam int TIMEOUT_CYCLES  = 300000;

    localparam logic signed [Q_W-1:0] Q_TOP    = 32'sh7FFFFFFF;
    localparam logic signed [Q_W-1:0] Q_BOTTOM = 32'sh80000000;

    // Word indexes with no register behind them
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  i_valid   = 1'b0;
    logic                  o_stall;
    logic signed [Q_W-1:0] i_vel_x   = '0;
    logic signed [Q_W-1:0] i_vel_y   = '0;
    logic signed [Q_W-1:0] i_pos_x   = '0;
    logic signed [Q_W-1:0] i_pos_y   = '0;
    logic signed [Q_W-1:0] i_accel_x = '0;
    logic signed [Q_W-1:0] i_accel_y = '0;
    logic                  o_valid;
    logic                  i_stall   = 1'b0;
    logic signed [Q_W-1:0] o_new_vel_x;
    logic signed [Q_W-1:0] o_new_vel_y;
    logic signed [Q_W-1:0] o_new_pos_x;
    logic signed [Q_W-1:0] o_new_pos_y;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_AW-1:0]     paddr     = '0;
    logic [APB_DW-1:0]     pwdata    = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int err_count;
    int pending;
    bit calm = 1'b0;

    // Settings currently in the unit, used to aim the random agents
    logic [EXT_W-1:0] cur_width    = RST_WINDOW;
    logic [EXT_W-1:0] cur_height   = RST_WINDOW;
    logic             cur_wrap     = 1'b0;
    logic [EXT_W-1:0] cur_wrap_lim = RST_SPEED_LIM;
    logic [EXT_W-1:0] cur_bnd_lim  = RST_SPEED_LIM;

    boid_euler_step_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_vel_x     (i_vel_x),
        .i_vel_y     (i_vel_y),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_accel_x   (i_accel_x),
        .i_accel_y   (i_accel_y),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_new_vel_x (o_new_vel_x),
        .o_new_vel_y (o_new_vel_y),
        .o_new_pos_x (o_new_pos_x),
        .o_new_pos_y (o_new_pos_y),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    beu_step_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_agent_valid (i_valid),
        .i_agent_stall (o_stall),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_new_vel_x   (o_new_vel_x),
        .i_new_vel_y   (o_new_vel_y),
        .i_new_pos_x   (o_new_pos_x),
        .i_new_pos_y   (o_new_pos_y),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_err_count   (err_count),
        .o_pending     (pending)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result channel at random, with odds of about 15 percent, never while calm
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < 15);
    end

    // Hard stop for a hung run
    initial begin
        #(12 * TIMEOUT_CYCLES);
        $display("tb_boid_euler_step_unit: done, errors");
        $finish;
    end

    // Present one agent, idling first at random, and hold it until its transfer
    task automatic push_agent(input logic signed [Q_W-1:0] vx, input logic signed [Q_W-1:0] vy,
                              input logic signed [Q_W-1:0] px, input logic signed [Q_W-1:0] py,
                              input logic signed [Q_W-1:0] ax, input logic signed [Q_W-1:0] ay);
        while (!calm && $urandom_range(0, 99) < 15) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_vel_x   <= vx;
        i_vel_y   <= vy;
        i_pos_x   <= px;
        i_pos_y   <= py;
        i_accel_x <= ax;
        i_accel_y <= ay;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop the agent valid and wait until every predicted update has been checked
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Register write: setup cycle, access cycle, then release the bus
    task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain, then write every register with noise in the unused upper bits
    task automatic apply_setup(input logic [DT_W-1:0] ts, input logic [EXT_W-1:0] w,
                               input logic [EXT_W-1:0] h, input logic mode,
                               input logic [EXT_W-1:0] wl, input logic [EXT_W-1:0] bl);
        logic [31:0] junk;
        wait_drained();
        junk = $urandom;
        write_reg(REG_TIME_STEP, {junk[31:16], ts});
        write_reg(REG_WINDOW_WIDTH, {junk[0], w});
        write_reg(REG_WINDOW_HEIGHT, {junk[1], h});
        write_reg(REG_WRAP_MODE, {junk[31:1], mode});
        write_reg(REG_WRAP_SPEED, {junk[2], wl});
        write_reg(REG_BOUNDED_SPEED, {junk[3], bl});
        write_reg(junk[4] ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        cur_width    = w;
        cur_height   = h;
        cur_wrap     = mode;
        cur_wrap_lim = wl;
        cur_bnd_lim  = bl;
    endtask

    function automatic logic [DT_W-1:0] rand_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DT_MAX;
            2:       return DT_W'($urandom_range(32769, 65535));
            default: return DT_W'($urandom_range(1, 32768));
        endcase
    endfunction

    function automatic logic [EXT_W-1:0] rand_extent();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return EXT_W'($urandom_range(0, 50 * Q_ONE));
            default: return EXT_W'($urandom_range(100 * Q_ONE, 2000 * Q_ONE));
        endcase
    endfunction

    function automatic logic [EXT_W-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return EXT_W'($urandom_range(1, 300 * Q_ONE));
        endcase
    endfunction

    // Q16.16 value: mostly within -span..span if centered, else over -span/16..17*span/16,
    // with full-range, extreme, near-zero and edge-margin values mixed in
    function automatic logic signed [Q_W-1:0] rand_q(input longint span, input bit centered);
        longint      v;
        longint      anchor;
        int unsigned reach;
        case ($urandom_range(0, 15))
            0, 1: v = longint'($signed($urandom));
            2:    v = Q_TOP;
            3:    v = Q_BOTTOM;
            4:    v = longint'($urandom_range(0, 4)) - 2;
            5, 6: begin
                case ($urandom_range(0, 3))
                    0:       anchor = 0;
                    1:       anchor = EDGE_MARGIN;
                    2:       anchor = span - EDGE_MARGIN;
                    default: anchor = span;
                endcase
                v = anchor + longint'($urandom_range(0, 64)) - 32;
            end
            default: begin
                if (centered) begin
                    reach = 32'(2 * span);
                    v = longint'($urandom_range(0, reach)) - span;
                end else begin
                    reach = 32'(span + span / 8);
                    v = longint'($urandom_range(0, reach)) - span / 16;
                end
            end
        endcase
        return v[Q_W-1:0];
    endfunction

    // Random agent aimed at the current window and speed limit
    task automatic random_agent();
        longint rate_span;
        longint accel_span;
        rate_span = cur_wrap ? longint'(cur_wrap_lim) : longint'(cur_bnd_lim);
        if (rate_span == 0) rate_span = 100 * Q_ONE;
        accel_span = rate_span * 8;
        if (accel_span > longint'(Q_TOP)) accel_span = Q_TOP;
        push_agent(rand_q(rate_span, 1'b1), rand_q(rate_span, 1'b1),
                   rand_q(longint'(cur_width), 1'b0), rand_q(longint'(cur_height), 1'b0),
                   rand_q(accel_span, 1'b1), rand_q(accel_span, 1'b1));
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, bounded space: edge margins, saturation, clamp
        push_agent(0, 0, 0, 0, 0, 0);
        push_agent(0, 0, EDGE_MARGIN, 780 * Q_ONE, 0, 0);
        push_agent(0, 0, EDGE_MARGIN - 1, 780 * Q_ONE + 1, 0, 0);
        push_agent(Q_TOP, Q_BOTTOM, 400 * Q_ONE, 400 * Q_ONE, Q_TOP, Q_BOTTOM);
        push_agent(Q_TOP, Q_BOTTOM, Q_TOP, Q_BOTTOM, 0, 0);
        push_agent(200 * Q_ONE, -200 * Q_ONE, 400 * Q_ONE, 400 * Q_ONE, Q_ONE, -Q_ONE);
        push_agent(-1, -1, -1, -1, -1, -1);
        push_agent(Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP, Q_TOP);
        push_agent(Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM);
        push_agent(3 * Q_ONE, -3 * Q_ONE, -5 * Q_ONE, 900 * Q_ONE, 0, 0);

        // Half step, toroidal space: rounding halves, wrap at both ends
        apply_setup(DT_MAX, EXT_W'(1000 * Q_ONE), '1, 1'b1, EXT_W'(50 * Q_ONE), '1);
        push_agent(0, 0, 10 * Q_ONE, 10 * Q_ONE, 1, -1);
        push_agent(0, 0, 10 * Q_ONE, 10 * Q_ONE, 3, -3);
        push_agent(1, -1, 10 * Q_ONE, 10 * Q_ONE, 0, 0);
        push_agent(0, 0, -1, -Q_ONE, 0, 0);
        push_agent(0, Q_TOP, 1000 * Q_ONE + 1, Q_TOP, 0, 0);
        push_agent(0, 0, 1000 * Q_ONE, 0, 0, 0);
        push_agent(60 * Q_ONE, -60 * Q_ONE, 500 * Q_ONE, 500 * Q_ONE, 0, 0);
        push_agent(Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM);

        // Oversized step, narrow bounded space: both edges push at once
        apply_setup(16'hFFFF, EXT_W'(30 * Q_ONE), '0, 1'b0, '0, EXT_W'(1000 * Q_ONE));
        push_agent(0, 0, 15 * Q_ONE, 0, 0, 0);
        push_agent(5 * Q_ONE, -Q_ONE, 10 * Q_ONE, -20 * Q_ONE, 2 * Q_ONE, 0);

        // Random agents under a series of settings, extremes first
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: apply_setup(16'hFFFF, EXT_W'(40 * Q_ONE), EXT_W'(30 * Q_ONE), 1'b0,
                               rand_limit(), EXT_W'(1000 * Q_ONE));
                1: apply_setup('0, '0, '1, 1'b1, '0, '1);
                2: apply_setup(DT_MAX, rand_extent(), rand_extent(), 1'b1, rand_limit(),
                               rand_limit());
                CALM_PHASE: apply_setup(RST_TIME_STEP, RST_WINDOW, RST_WINDOW, 1'b0, '1,
                                        RST_SPEED_LIM);
                default: apply_setup(rand_step(), rand_extent(), rand_extent(),
                                     1'($urandom_range(0, 1)), rand_limit(), rand_limit());
            endcase
            calm = (ph == CALM_PHASE);
            repeat (ITEMS_PER_PHASE) random_agent();
            calm = 1'b0;
        end

        // Wait out the pipeline, then the verdict
        wait_drained();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("tb_boid_euler_step_unit: done, clean");
        end else begin
            $display("tb_boid_euler_step_unit: done, errors");
        end
        $finish;
    end

endmodule
